### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition must never be seen at a clock edge out of reset.
`define CHK_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define CHK_ASSERT(lbl, clk, rstn, prop, msg)
`define CHK_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### hw/rtl/mi3_pkg.sv
package mi3_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int N_ENT  = 9;
    localparam int PROD_W = 2 * DATA_W;
    localparam int COF_W  = PROD_W + 1;
    localparam int DET_W  = DATA_W + COF_W + 2;
    localparam int Q_W    = DATA_W;
    localparam int DIV_W  = DET_W + Q_W;
    // front end 7, one per quotient bit, round, saturate
    localparam int N_STG  = 9 + Q_W;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic signed [DET_W-1:0]  t_det;
    typedef logic [DIV_W-1:0]         t_rem;
    typedef logic [Q_W-1:0]           t_quo;

    // Operand pairs of the 18 cofactor products; cofactor k = p[2k] - p[2k+1]
    localparam logic [3:0] MUL_A [2*N_ENT] =
        '{4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
          4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
    localparam logic [3:0] MUL_B [2*N_ENT] =
        '{4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
          4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};
    // Cofactors that pair with the first row in the determinant
    localparam logic [3:0] DET_COF [3] = '{4'd0, 4'd3, 4'd6};

endpackage

### hw/rtl/matrix_inverse_3x3_core.sv
// 3x3 signed Q16.16 matrix inverse by adjugate over determinant.
// Pipeline: 7 front-end stages, one restoring-division stage per quotient bit (32),
// rounding, saturation.
// Throughput: one transaction per cycle; the whole pipe holds while a result is stalled.
// Reset: synchronous, active low, clears only the stage valid bits.
module matrix_inverse_3x3_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  mi3_pkg::t_data i_a00,
    input  mi3_pkg::t_data i_a01,
    input  mi3_pkg::t_data i_a02,
    input  mi3_pkg::t_data i_a10,
    input  mi3_pkg::t_data i_a11,
    input  mi3_pkg::t_data i_a12,
    input  mi3_pkg::t_data i_a20,
    input  mi3_pkg::t_data i_a21,
    input  mi3_pkg::t_data i_a22,
    output logic           o_valid,
    input  logic           i_stall,
    output mi3_pkg::t_data o_b00,
    output mi3_pkg::t_data o_b01,
    output mi3_pkg::t_data o_b02,
    output mi3_pkg::t_data o_b10,
    output mi3_pkg::t_data o_b11,
    output mi3_pkg::t_data o_b12,
    output mi3_pkg::t_data o_b20,
    output mi3_pkg::t_data o_b21,
    output mi3_pkg::t_data o_b22,
    output logic           o_singular,
    output logic           o_overflow
);
    import mi3_pkg::*;
`include "assert_macros.svh"

    localparam logic [Q_W:0] Q_LIM = (Q_W+1)'(1) << (Q_W - 1);
    localparam t_data D_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_data D_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // One valid bit per stage; the pipe moves as a whole unless the
    // output register holds a transaction that is being stalled.
    logic [N_STG-1:0] r_vld;
    logic             w_adv;
    t_data            w_a [N_ENT];

    assign w_adv   = !(r_vld[N_STG-1] && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_vld[N_STG-1];

    assign w_a = '{i_a00, i_a01, i_a02, i_a10, i_a11, i_a12, i_a20, i_a21, i_a22};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[N_STG-2:0], i_valid};
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: the 18 exact 32x32 products of the 2x2 minors
    // Stage 2: nine cofactors (65 bits, exact)
    // Stage 3: first-row x cofactor split into low/high partial products
    // Stage 4: recombine partials; cofactor magnitudes and signs
    // Stage 5: determinant sum
    // Stage 6: |det|, zero test, result signs, scaled numerators
    // Stage 7: overflow precheck (quotient would need more than 32 bits)
    // ---------------------------------------------------------------
    t_prod                r1_p   [2*N_ENT];
    t_data                r1_a   [3];
    t_cof                 r2_cof [N_ENT];
    t_data                r2_a   [3];
    t_det                 r3_pl  [3];
    t_det                 r3_ph  [3];
    t_cof                 r3_cof [N_ENT];
    t_det                 r4_term[3];
    logic [COF_W-1:0]     r4_mag [N_ENT];
    logic [N_ENT-1:0]     r4_cneg;
    t_det                 r5_det;
    logic [COF_W-1:0]     r5_mag [N_ENT];
    logic [N_ENT-1:0]     r5_cneg;

    // Division chain: index 0 is stage 7, index j+1 follows quotient bit j
    t_rem                 r_drem [Q_W+1][N_ENT];
    t_quo                 r_dq   [Q_W+1][N_ENT];
    logic [DET_W-1:0]     r_ddabs[Q_W+1];
    logic                 r_dzero[Q_W+1];
    logic [N_ENT-1:0]     r_dneg [Q_W+1];
    logic [N_ENT-1:0]     r_dbig [Q_W+1];

    // Stage 6 holds its own copy so the precheck reads registered |det|
    t_rem                 r6_rem [N_ENT];
    logic [DET_W-1:0]     r6_dabs;
    logic                 r6_zero;
    logic [N_ENT-1:0]     r6_neg;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < 2*N_ENT; j++) begin
                r1_p[j] <= t_prod'(w_a[MUL_A[j]]) * t_prod'(w_a[MUL_B[j]]);
            end
            for (int i = 0; i < 3; i++) begin
                r1_a[i] <= w_a[i];
                r2_a[i] <= r1_a[i];
            end
            for (int k = 0; k < N_ENT; k++) begin
                r2_cof[k] <= t_cof'(r1_p[2*k]) - t_cof'(r1_p[2*k+1]);
                r3_cof[k] <= r2_cof[k];
            end
            for (int i = 0; i < 3; i++) begin
                r3_pl[i] <= t_det'(r2_a[i])
                    * t_det'({1'b0, r2_cof[DET_COF[i]][DATA_W-1:0]});
                r3_ph[i] <= t_det'(r2_a[i])
                    * t_det'($signed(r2_cof[DET_COF[i]][COF_W-1:DATA_W]));
                r4_term[i] <= r3_pl[i] + (r3_ph[i] <<< DATA_W);
            end
            for (int k = 0; k < N_ENT; k++) begin
                r4_mag[k]  <= r3_cof[k][COF_W-1] ? unsigned'(-r3_cof[k])
                                                 : unsigned'(r3_cof[k]);
                r4_cneg[k] <= r3_cof[k][COF_W-1];
                r5_mag[k]  <= r4_mag[k];
            end
            r5_cneg <= r4_cneg;
            r5_det  <= r4_term[0] + r4_term[1] + r4_term[2];

            r6_dabs <= r5_det[DET_W-1] ? unsigned'(-r5_det) : unsigned'(r5_det);
            r6_zero <= (r5_det == '0);
            r6_neg  <= r5_cneg ^ {N_ENT{r5_det[DET_W-1]}};
            for (int k = 0; k < N_ENT; k++) begin
                r6_rem[k] <= t_rem'(r5_mag[k]) << (2 * FRAC_W);
            end

            // quotient >= 2^Q_W iff numerator >= |det| * 2^Q_W
            r_ddabs[0] <= r6_dabs;
            r_dzero[0] <= r6_zero;
            r_dneg[0]  <= r6_neg;
            for (int k = 0; k < N_ENT; k++) begin
                r_drem[0][k]   <= r6_rem[k];
                r_dq[0][k]     <= '0;
                r_dbig[0][k]   <= (r6_rem[k] >= (t_rem'(r6_dabs) << Q_W));
            end
        end
    end

    // Restoring division, one quotient bit per stage, MSB first.
    // Remainder stays below |det| << (bit+1), so the trial difference
    // never wraps and its top bit is the borrow.
    for (genvar j = 0; j < Q_W; j++) begin : g_div
        for (genvar k = 0; k < N_ENT; k++) begin : g_ent
            t_rem w_trial;
            assign w_trial = r_drem[j][k] - (t_rem'(r_ddabs[j]) << (Q_W - 1 - j));
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_drem[j+1][k] <= w_trial[DIV_W-1] ? r_drem[j][k] : w_trial;
                    r_dq[j+1][k]   <= {r_dq[j][k][Q_W-2:0], !w_trial[DIV_W-1]};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_ddabs[j+1] <= r_ddabs[j];
                r_dzero[j+1] <= r_dzero[j];
                r_dneg[j+1]  <= r_dneg[j];
                r_dbig[j+1]  <= r_dbig[j];
            end
        end
    end

    // Round to nearest, ties away from zero: bump when 2*rem >= |det|
    logic [Q_W:0]     r_rq [N_ENT];
    logic             r_rzero;
    logic [N_ENT-1:0] r_rneg;
    logic [N_ENT-1:0] r_rbig;

    // Output register
    t_data            r_ob [N_ENT];
    logic             r_osing;
    logic             r_oovf;

    logic [N_ENT-1:0] w_sat;
    t_data            w_val [N_ENT];

    always_comb begin
        for (int k = 0; k < N_ENT; k++) begin
            w_sat[k] = r_rbig[k] || (r_rneg[k] ? (r_rq[k] > Q_LIM) : (r_rq[k] >= Q_LIM));
            if (w_sat[k]) begin
                w_val[k] = r_rneg[k] ? D_MIN : D_MAX;
            end else if (r_rneg[k]) begin
                w_val[k] = t_data'(-r_rq[k][Q_W-1:0]);
            end else begin
                w_val[k] = t_data'(r_rq[k][Q_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < N_ENT; k++) begin
                r_rq[k] <= {1'b0, r_dq[Q_W][k]}
                    + (Q_W+1)'((r_drem[Q_W][k] << 1) >= t_rem'(r_ddabs[Q_W]));
            end
            r_rzero <= r_dzero[Q_W];
            r_rneg  <= r_dneg[Q_W];
            r_rbig  <= r_dbig[Q_W];

            // zero determinant: all entries zero, no overflow
            for (int k = 0; k < N_ENT; k++) begin
                r_ob[k] <= r_rzero ? '0 : w_val[k];
            end
            r_osing <= r_rzero;
            r_oovf  <= !r_rzero && (|w_sat);
        end
    end

    assign o_b00      = r_ob[0];
    assign o_b01      = r_ob[1];
    assign o_b02      = r_ob[2];
    assign o_b10      = r_ob[3];
    assign o_b11      = r_ob[4];
    assign o_b12      = r_ob[5];
    assign o_b20      = r_ob[6];
    assign o_b21      = r_ob[7];
    assign o_b22      = r_ob[8];
    assign o_singular = r_osing;
    assign o_overflow = r_oovf;

    // A singular transaction never reports saturation
    `CHK_NEVER(a_sing_ovf, i_clk, i_rst_n, o_valid && o_singular && o_overflow, "singular with overflow")
    // A singular transaction carries zero in entries b00, b11, b22 and b02
    `CHK_ASSERT(a_sing_zero, i_clk, i_rst_n, (o_valid && o_singular) |-> (o_b00 == '0 && o_b11 == '0 && o_b22 == '0 && o_b02 == '0), "singular result not zero")
    // While a held result is stalled the pipe does not take a transaction
    `CHK_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && i_stall) |-> o_stall, "input taken during output stall")

endmodule

### sim/matrix_inverse_3x3_core_tb.sv
module matrix_inverse_3x3_core_tb;
    import mi3_pkg::*;

    localparam int N_RANDOM  = 1530;
    localparam int CYC_LIMIT = 400000;
    localparam int TAIL_CYC  = 60;
    localparam logic signed [31:0] ONE_Q = 32'sd65536;

    typedef struct {
        t_data a [9];
        bit    drain;   // sender holds until every result is back
    } t_mat;

    typedef struct {
        t_data b [9];
        bit    sing;
        bit    ovf;
    } t_inv;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   out_stall = 1'b0;
    t_data  drv_a [9] = '{default: '0};
    logic   in_stall;
    logic   out_valid;
    t_data  got_b [9];
    logic   got_sing, got_ovf;

    t_mat   pend_q [$];
    t_inv   inv_q [$];
    int     cyc = 0;
    int     n_err = 0;
    int     n_res = 0;
    int     n_sing = 0;
    int     n_ovf = 0;

    always #1 clk = ~clk;

    matrix_inverse_3x3_core uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_a00(drv_a[0]), .i_a01(drv_a[1]), .i_a02(drv_a[2]),
        .i_a10(drv_a[3]), .i_a11(drv_a[4]), .i_a12(drv_a[5]),
        .i_a20(drv_a[6]), .i_a21(drv_a[7]), .i_a22(drv_a[8]),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_b00(got_b[0]), .o_b01(got_b[1]), .o_b02(got_b[2]),
        .o_b10(got_b[3]), .o_b11(got_b[4]), .o_b12(got_b[5]),
        .o_b20(got_b[6]), .o_b21(got_b[7]), .o_b22(got_b[8]),
        .o_singular(got_sing), .o_overflow(got_ovf)
    );

    // exact adjugate / determinant, rounded half away from zero, saturated
    function automatic t_inv inverse_of(t_mat m);
        logic signed [191:0] e [9];
        logic signed [191:0] cof [9];
        logic signed [191:0] det, dabs, num, q, r, lim;
        t_inv res;
        bit   neg;
        for (int k = 0; k < 9; k++) e[k] = m.a[k];
        cof[0] = e[4]*e[8] - e[5]*e[7];
        cof[1] = e[2]*e[7] - e[1]*e[8];
        cof[2] = e[1]*e[5] - e[2]*e[4];
        cof[3] = e[5]*e[6] - e[3]*e[8];
        cof[4] = e[0]*e[8] - e[2]*e[6];
        cof[5] = e[2]*e[3] - e[0]*e[5];
        cof[6] = e[3]*e[7] - e[4]*e[6];
        cof[7] = e[1]*e[6] - e[0]*e[7];
        cof[8] = e[0]*e[4] - e[1]*e[3];
        det = e[0]*cof[0] + e[1]*cof[3] + e[2]*cof[6];
        res.sing = (det == 0);
        res.ovf  = 1'b0;
        lim = 192'sd1 <<< (DATA_W - 1);
        dabs = (det < 0) ? -det : det;
        for (int k = 0; k < 9; k++) begin
            res.b[k] = '0;
            if (!res.sing) begin
                neg = (cof[k] < 0) != (det < 0);
                num = ((cof[k] < 0) ? -cof[k] : cof[k]) <<< (2 * FRAC_W);
                q = num / dabs;
                r = num - q * dabs;
                if (2 * r >= dabs) q = q + 1;
                if (!neg) begin
                    if (q >= lim) begin
                        res.b[k] = {1'b0, {(DATA_W-1){1'b1}}};
                        res.ovf = 1'b1;
                    end else res.b[k] = q[DATA_W-1:0];
                end else begin
                    if (q > lim) begin
                        res.b[k] = {1'b1, {(DATA_W-1){1'b0}}};
                        res.ovf = 1'b1;
                    end else res.b[k] = -q[DATA_W-1:0];
                end
            end
        end
        return res;
    endfunction

    function automatic t_data pick_edge();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            3: return 32'sd1;
            4: return -32'sd1;
            5: return ONE_Q;
            6: return -ONE_Q;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_data pick_small(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_mat rand_matrix();
        t_mat m;
        int   mode, src, dst, f;
        m.drain = 1'b0;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++) begin
            case (mode)
                0, 1: m.a[k] = $urandom;
                7:    m.a[k] = pick_edge();
                8:    m.a[k] = pick_small(512);
                default: m.a[k] = pick_small(4 * 65536);
            endcase
        end
        if (mode == 6) begin
            // one row a small multiple of another: exactly singular
            src = $urandom_range(0, 2);
            dst = (src + $urandom_range(1, 2)) % 3;
            f = $urandom_range(0, 6) - 3;
            for (int c = 0; c < 3; c++) m.a[3*dst + c] = m.a[3*src + c] * f;
        end
        if (mode == 9)
            for (int k = 0; k < 9; k++)
                if (k % 4 != 0) m.a[k] = pick_small(64);
        return m;
    endfunction

    function automatic t_mat diag(t_data d0, t_data d1, t_data d2);
        t_mat m;
        m.drain = 1'b0;
        m.a = '{default: '0};
        m.a[0] = d0; m.a[4] = d1; m.a[8] = d2;
        return m;
    endfunction

    function automatic bit idle_now();
        if (cyc >= 1500 && cyc < 2500) return 1'b0;
        return $urandom_range(0, 99) < 20;
    endfunction

    // driver: next transaction from pend_q, held steady while stalled
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (pend_q.size() != 0 && pend_q[0].drain && (inv_q.size() != 0 || in_valid)) begin
                in_valid <= 1'b0;
            end else if (pend_q.size() != 0 && !idle_now()) begin
                drv_a <= pend_q[0].a;
                in_valid <= 1'b1;
                void'(pend_q.pop_front());
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= idle_now();
    end

    // monitor: predict on input transactions, compare on output transactions
    always @(posedge clk) begin
        t_mat cur;
        t_inv exp_r;
        cyc <= cyc + 1;
        if (rst_n && in_valid && !in_stall) begin
            cur.a = drv_a;
            cur.drain = 1'b0;
            inv_q.push_back(inverse_of(cur));
        end
        if (rst_n && out_valid && !out_stall) begin
            if (inv_q.size() == 0) begin
                $display("%0t: result with nothing expected", $time);
                n_err++;
            end else begin
                exp_r = inv_q.pop_front();
                n_res++;
                n_sing += exp_r.sing;
                n_ovf += exp_r.ovf;
                for (int k = 0; k < 9; k++)
                    if (got_b[k] !== exp_r.b[k]) begin
                        $display("%0t: b%0d%0d expected %h got %h", $time, k / 3, k % 3,
                                 exp_r.b[k], got_b[k]);
                        n_err++;
                    end
                if (got_sing !== exp_r.sing) begin
                    $display("%0t: singular expected %b got %b", $time, exp_r.sing, got_sing);
                    n_err++;
                end
                if (got_ovf !== exp_r.ovf) begin
                    $display("%0t: overflow expected %b got %b", $time, exp_r.ovf, got_ovf);
                    n_err++;
                end
            end
        end
        if (cyc > CYC_LIMIT) begin
            $display("timeout at cycle %0d", cyc);
            $display("matrix_inverse_3x3_core_tb: errors");
            $finish;
        end
    end

    initial begin
        t_mat m;
        // directed: identity, zero, extremes, scaling, rounding ties
        pend_q.push_back(diag(ONE_Q, ONE_Q, ONE_Q));
        pend_q.push_back(diag(0, 0, 0));
        pend_q.push_back(diag(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        pend_q.push_back(diag(32'sh80000000, 32'sh80000000, 32'sh80000000));
        pend_q.push_back(diag(32'sh80000000, 32'sh7fffffff, -ONE_Q));
        pend_q.push_back(diag(32'sd1, 32'sd1, 32'sd1));
        pend_q.push_back(diag(-32'sd1, ONE_Q, ONE_Q));
        pend_q.push_back(diag(2 * ONE_Q, 4 * ONE_Q, -8 * ONE_Q));
        pend_q.push_back(diag(3 * ONE_Q, -3 * ONE_Q, 7 * ONE_Q));
        pend_q.push_back(diag(32'sd131072, 32'sd131072, ONE_Q)); // halves
        pend_q.push_back(diag(32'sd2, ONE_Q, ONE_Q));            // exact 2^31 bound
        pend_q.push_back(diag(-32'sd2, ONE_Q, ONE_Q));
        pend_q.push_back(diag(32'sd3, ONE_Q, ONE_Q));
        m.drain = 1'b0;
        m.a = '{default: 32'sh7fffffff};
        pend_q.push_back(m);
        m.a = '{default: 32'sh80000000};
        pend_q.push_back(m);
        m.a = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                32'sh80000000, 32'sh7fffffff, 32'sh7fffffff};
        pend_q.push_back(m);
        m.a = '{ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 0, ONE_Q, 4 * ONE_Q,
                5 * ONE_Q, 6 * ONE_Q, 0};
        pend_q.push_back(m);
        m.a = '{ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 4 * ONE_Q, 5 * ONE_Q, 6 * ONE_Q,
                7 * ONE_Q, 8 * ONE_Q, 9 * ONE_Q};
        pend_q.push_back(m);
        m.a = '{32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f, 32'shf0f0f0f0,
                32'sh33333333, 32'shcccccccc, 32'sh01234567, 32'sh89abcdef, 32'sh7edcba98};
        pend_q.push_back(m);
        for (int n = 0; n < N_RANDOM; n++) begin
            m = rand_matrix();
            if (n == N_RANDOM / 2 || n == N_RANDOM / 4) m.drain = 1'b1;
            pend_q.push_back(m);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || in_valid || inv_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);
        $display("%0d inverses checked: %0d singular, %0d saturated, random stalls both sides",
                 n_res, n_sing, n_ovf);
        if (n_err == 0) begin
            $display("matrix_inverse_3x3_core_tb: clean");
        end else begin
            $display("matrix_inverse_3x3_core_tb: errors");
        end
        $finish;
    end
endmodule

### matrix_inverse_3x3_core.f
+incdir+hw/rtl
hw/rtl/mi3_pkg.sv
hw/rtl/matrix_inverse_3x3_core.sv
sim/matrix_inverse_3x3_core_tb.sv
